[sv/adr_pkg.sv]
package adr_pkg;

    localparam int ADJ_FRAC  = 22;
    localparam int ADJ_W     = 24;
    localparam int EPS_W     = 16;
    localparam int V_W       = 16;
    localparam int T_W       = 31;
    localparam int R_W       = 62;
    localparam int SQ_STEPS  = R_W / 2;
    localparam int MUL_W     = 32;
    localparam int ACC_W     = 2 * MUL_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ADJ_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJ_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd2;

    localparam logic [ADJ_W-1:0] ADJ_RESET = 24'h400000;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam logic FUNC_PRESS = 1'b0;
    localparam logic FUNC_DRAG  = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE, S_MX, S_TX, S_MY, S_TY, S_R2A, S_R2B, S_SQI, S_SQ, S_SQD,
        S_DVX, S_QX, S_DVYI, S_DVY, S_QY, S_ROUTE,
        S_CX0, S_CX1, S_CXW, S_CY0, S_CY1, S_CYW, S_CZ0, S_CZ1, S_CZW,
        S_W0, S_W1, S_W2, S_WW, S_M0, S_M1, S_M2, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        M_NONE, M_PXAW, M_PYAH, M_TXTX, M_TYTY,
        M_AYBZ, M_AZBY, M_AZBX, M_AXBZ, M_AXBY, M_AYBX,
        M_AXBX, M_AYBY, M_AZBZ, M_CXCX, M_CYCY, M_CZCZ
    } t_mop;

    typedef enum logic [1:0] {
        A_NONE, A_LOAD, A_ADD, A_SUB
    } t_aop;

    typedef enum logic [4:0] {
        W_NONE, W_IN, W_TX, W_TY, W_SQ_INIT, W_SQ_STEP, W_E_IN,
        W_DV_INIT_X, W_DV_INIT_Y, W_DV_STEP, W_EX_Q, W_EY_Q, W_START,
        W_CX, W_CY, W_CZ, W_W, W_OUT
    } t_wop;

    typedef struct packed {
        t_mop mop;
        t_aop aop;
        t_wop wop;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic outside;
    } t_status;

endpackage

[sv/arcball_drag_rotation.sv]
// Arcball drag controller. Pointer events enter as beats on the slave
// channel: tdata carries the pixel column and row, tuser selects press (0)
// or drag (1). A press maps the point onto the unit sphere and keeps it as
// the start vector; it produces no output beat. A drag maps the point and
// sends one beat on the master channel with the rotation quaternion
// (cross product in x, y, z and dot product in w, signed Q2.14) and a
// coincident flag in tuser.
// Scale factors and the coincidence threshold are set through the register
// write port; the user must write them only while no event is in flight, as
// the block itself does not enforce this. A point inside the circle is mapped
// through the 31-step square root; a point outside it is also normalized onto
// the rim by two bit-serial divisions. The square root and the divisions run
// in the shared datapath; products use a single multiplier one term per cycle.
// One event is processed at a time. The slave side is ready only between
// events. A finished result sits in the output register; while the receiver
// stalls the next event is still accepted and processed, and only its own
// result waits for the register to free. Reset restores the default scales
// and threshold, clears the start vector and drops any pending output beat.
module arcball_drag_rotation #(
    parameter int PIXEL_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // pix_x, pix_y, zero padding
    input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]     i_s_tdata,
    // func
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [4*adr_pkg::V_W-1:0]             o_m_tdata,
    // coincident
    output logic                                  o_m_tuser,
    input  logic                                  i_cfg_we,
    input  logic [adr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [adr_pkg::ADJ_W-1:0]             i_cfg_data
);
    import adr_pkg::*;

    t_cmd                  cmd;
    t_status               status;
    logic signed [V_W-1:0] quat_x, quat_y, quat_z, quat_w;

    adr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    adr_dpath #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_s_tuser),
        .i_pix_x      (i_s_tdata[PIXEL_BITS-1:0]),
        .i_pix_y      (i_s_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_quat_x     (quat_x),
        .o_quat_y     (quat_y),
        .o_quat_z     (quat_z),
        .o_quat_w     (quat_w),
        .o_coincident (o_m_tuser)
    );

    assign o_m_tdata = {quat_w, quat_z, quat_y, quat_x};

endmodule

[sv/adr_ctrl.sv]
module adr_ctrl #(
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  adr_pkg::t_status i_status,
    output adr_pkg::t_cmd    o_cmd
);
    import adr_pkg::*;

    localparam int QB      = FRAC_BITS + 1;
    localparam int CNT_MAX = (SQ_STEPS > QB) ? SQ_STEPS : QB;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(SQ_STEPS - 1);
    localparam logic [CNT_W-1:0] DV_LAST = CNT_W'(QB - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_mvalid, n_mvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_mvalid <= n_mvalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_mvalid   = r_mvalid && !i_m_tready;
        o_cmd      = '{mop: M_NONE, aop: A_NONE, wop: W_NONE};
        o_s_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.wop = W_IN;
                    n_state   = S_MX;
                end
            end
            S_MX: begin
                o_cmd.mop = M_PXAW; o_cmd.aop = A_LOAD; n_state = S_TX;
            end
            S_TX: begin
                o_cmd.wop = W_TX; n_state = S_MY;
            end
            S_MY: begin
                o_cmd.mop = M_PYAH; o_cmd.aop = A_LOAD; n_state = S_TY;
            end
            S_TY: begin
                o_cmd.wop = W_TY; n_state = S_R2A;
            end
            S_R2A: begin
                o_cmd.mop = M_TXTX; o_cmd.aop = A_LOAD; n_state = S_R2B;
            end
            S_R2B: begin
                o_cmd.mop = M_TYTY; o_cmd.aop = A_ADD; n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.wop = W_SQ_INIT; n_cnt = '0; n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.wop = W_SQ_STEP;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    n_state = S_SQD;
                end
            end
            S_SQD: begin
                n_cnt = '0;
                if (i_status.outside) begin
                    o_cmd.wop = W_DV_INIT_X; n_state = S_DVX;
                end else begin
                    o_cmd.wop = W_E_IN; n_state = S_ROUTE;
                end
            end
            S_DVX: begin
                o_cmd.wop = W_DV_STEP;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DV_LAST) begin
                    n_state = S_QX;
                end
            end
            S_QX: begin
                o_cmd.wop = W_EX_Q; n_state = S_DVYI;
            end
            S_DVYI: begin
                o_cmd.wop = W_DV_INIT_Y; n_cnt = '0; n_state = S_DVY;
            end
            S_DVY: begin
                o_cmd.wop = W_DV_STEP;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DV_LAST) begin
                    n_state = S_QY;
                end
            end
            S_QY: begin
                o_cmd.wop = W_EY_Q; n_state = S_ROUTE;
            end
            S_ROUTE: begin
                if (i_status.func == FUNC_PRESS) begin
                    o_cmd.wop = W_START; n_state = S_IDLE;
                end else begin
                    n_state = S_CX0;
                end
            end
            S_CX0: begin o_cmd.mop = M_AYBZ; o_cmd.aop = A_LOAD; n_state = S_CX1; end
            S_CX1: begin o_cmd.mop = M_AZBY; o_cmd.aop = A_SUB;  n_state = S_CXW; end
            S_CXW: begin o_cmd.wop = W_CX; n_state = S_CY0; end
            S_CY0: begin o_cmd.mop = M_AZBX; o_cmd.aop = A_LOAD; n_state = S_CY1; end
            S_CY1: begin o_cmd.mop = M_AXBZ; o_cmd.aop = A_SUB;  n_state = S_CYW; end
            S_CYW: begin o_cmd.wop = W_CY; n_state = S_CZ0; end
            S_CZ0: begin o_cmd.mop = M_AXBY; o_cmd.aop = A_LOAD; n_state = S_CZ1; end
            S_CZ1: begin o_cmd.mop = M_AYBX; o_cmd.aop = A_SUB;  n_state = S_CZW; end
            S_CZW: begin o_cmd.wop = W_CZ; n_state = S_W0; end
            S_W0:  begin o_cmd.mop = M_AXBX; o_cmd.aop = A_LOAD; n_state = S_W1; end
            S_W1:  begin o_cmd.mop = M_AYBY; o_cmd.aop = A_ADD;  n_state = S_W2; end
            S_W2:  begin o_cmd.mop = M_AZBZ; o_cmd.aop = A_ADD;  n_state = S_WW; end
            S_WW:  begin o_cmd.wop = W_W; n_state = S_M0; end
            S_M0:  begin o_cmd.mop = M_CXCX; o_cmd.aop = A_LOAD; n_state = S_M1; end
            S_M1:  begin o_cmd.mop = M_CYCY; o_cmd.aop = A_ADD;  n_state = S_M2; end
            S_M2:  begin o_cmd.mop = M_CZCZ; o_cmd.aop = A_ADD;  n_state = S_OUT; end
            S_OUT: begin
                if (!r_mvalid || i_m_tready) begin
                    o_cmd.wop = W_OUT;
                    n_mvalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_mvalid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state == S_MX))
        else $error("accepted beat did not start the mapping sequence");

    a_sqrt_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ && r_cnt == SQ_LAST) |=> (r_state == S_SQD))
        else $error("square root did not end after its last step");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_mvalid || i_m_tready)) |=>
        (r_mvalid && r_state == S_IDLE))
        else $error("result was not presented when the output was free");

endmodule

[sv/adr_dpath.sv]
module adr_dpath #(
    parameter int PIXEL_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [adr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [adr_pkg::ADJ_W-1:0]          i_cfg_data,
    input  logic                               i_func,
    input  logic [PIXEL_BITS-1:0]              i_pix_x,
    input  logic [PIXEL_BITS-1:0]              i_pix_y,
    input  adr_pkg::t_cmd                      i_cmd,
    output adr_pkg::t_status                   o_status,
    output logic signed [adr_pkg::V_W-1:0]     o_quat_x,
    output logic signed [adr_pkg::V_W-1:0]     o_quat_y,
    output logic signed [adr_pkg::V_W-1:0]     o_quat_z,
    output logic signed [adr_pkg::V_W-1:0]     o_quat_w,
    output logic                               o_coincident
);
    import adr_pkg::*;

    localparam int SH   = ADJ_FRAC - FRAC_BITS;
    localparam int QB   = FRAC_BITS + 1;
    localparam int SQ_W = SQ_STEPS;
    localparam int NW   = T_W + FRAC_BITS + 1;
    localparam int DW   = SQ_W + FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ONE22 = ACC_W'(1) << ADJ_FRAC;
    localparam logic signed [ACC_W-1:0] T_MAX = (ACC_W'(1) << (T_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] T_MIN = -T_MAX;
    localparam logic signed [ACC_W-1:0] V_MAX = (ACC_W'(1) << (V_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] V_MIN = -(ACC_W'(1) << (V_W - 1));
    localparam logic [R_W-1:0]          ONE2  = R_W'(1) << (2 * FRAC_BITS);
    localparam logic [R_W-1:0]          BIT0  = R_W'(1) << (R_W - 2);

    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                     input int sh);
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) << (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [T_W-1:0] clamp_t(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > T_MAX) ? T_MAX : ((v < T_MIN) ? T_MIN : v);
        return c[T_W-1:0];
    endfunction

    function automatic logic signed [V_W-1:0] sat_v(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > V_MAX) ? V_MAX : ((v < V_MIN) ? V_MIN : v);
        return c[V_W-1:0];
    endfunction

    logic                    r_func, n_func;
    logic [PIXEL_BITS-1:0]   r_px, n_px, r_py, n_py;
    logic [ADJ_W-1:0]        r_adj_w, n_adj_w, r_adj_h, n_adj_h;
    logic [EPS_W-1:0]        r_eps, n_eps;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [T_W-1:0]   r_tx, n_tx, r_ty, n_ty;
    logic                    r_outside, n_outside;
    logic [R_W-1:0]          r_sq_v, n_sq_v, r_sq_res, n_sq_res, r_sq_bit, n_sq_bit;
    logic [NW-1:0]           r_dv_rem, n_dv_rem;
    logic [DW-1:0]           r_dv_den, n_dv_den;
    logic [QB-1:0]           r_dv_q, n_dv_q;
    logic signed [V_W-1:0]   r_ex, n_ex, r_ey, n_ey, r_ez, n_ez;
    logic signed [V_W-1:0]   r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic signed [V_W-1:0]   r_cx, n_cx, r_cy, n_cy, r_cz, n_cz, r_w, n_w;
    logic signed [V_W-1:0]   r_qx, n_qx, r_qy, n_qy, r_qz, n_qz, r_qw, n_qw;
    logic                    r_coin, n_coin;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] prod;
    logic [R_W-1:0]          sq_trial;
    logic [SQ_W-1:0]         sq_s;
    logic signed [T_W-1:0]   dv_p;
    logic [T_W-1:0]          dv_mag;
    logic signed [ACC_W-1:0] dv_qs;
    logic                    coin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_w <= ADJ_RESET;
            r_adj_h <= ADJ_RESET;
            r_eps   <= EPS_RESET;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sz    <= '0;
        end else begin
            r_adj_w <= n_adj_w;
            r_adj_h <= n_adj_h;
            r_eps   <= n_eps;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_sz    <= n_sz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_px      <= n_px;
        r_py      <= n_py;
        r_acc     <= n_acc;
        r_tx      <= n_tx;
        r_ty      <= n_ty;
        r_outside <= n_outside;
        r_sq_v    <= n_sq_v;
        r_sq_res  <= n_sq_res;
        r_sq_bit  <= n_sq_bit;
        r_dv_rem  <= n_dv_rem;
        r_dv_den  <= n_dv_den;
        r_dv_q    <= n_dv_q;
        r_ex      <= n_ex;
        r_ey      <= n_ey;
        r_ez      <= n_ez;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_cz      <= n_cz;
        r_w       <= n_w;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_qz      <= n_qz;
        r_qw      <= n_qw;
        r_coin    <= n_coin;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mop)
            M_NONE: begin mul_a = '0; mul_b = '0; end
            M_PXAW: begin
                mul_a = $signed(MUL_W'(r_px)); mul_b = $signed(MUL_W'(r_adj_w));
            end
            M_PYAH: begin
                mul_a = $signed(MUL_W'(r_py)); mul_b = $signed(MUL_W'(r_adj_h));
            end
            M_TXTX: begin mul_a = MUL_W'(r_tx); mul_b = MUL_W'(r_tx); end
            M_TYTY: begin mul_a = MUL_W'(r_ty); mul_b = MUL_W'(r_ty); end
            M_AYBZ: begin mul_a = MUL_W'(r_sy); mul_b = MUL_W'(r_ez); end
            M_AZBY: begin mul_a = MUL_W'(r_sz); mul_b = MUL_W'(r_ey); end
            M_AZBX: begin mul_a = MUL_W'(r_sz); mul_b = MUL_W'(r_ex); end
            M_AXBZ: begin mul_a = MUL_W'(r_sx); mul_b = MUL_W'(r_ez); end
            M_AXBY: begin mul_a = MUL_W'(r_sx); mul_b = MUL_W'(r_ey); end
            M_AYBX: begin mul_a = MUL_W'(r_sy); mul_b = MUL_W'(r_ex); end
            M_AXBX: begin mul_a = MUL_W'(r_sx); mul_b = MUL_W'(r_ex); end
            M_AYBY: begin mul_a = MUL_W'(r_sy); mul_b = MUL_W'(r_ey); end
            M_AZBZ: begin mul_a = MUL_W'(r_sz); mul_b = MUL_W'(r_ez); end
            M_CXCX: begin mul_a = MUL_W'(r_cx); mul_b = MUL_W'(r_cx); end
            M_CYCY: begin mul_a = MUL_W'(r_cy); mul_b = MUL_W'(r_cy); end
            M_CZCZ: begin mul_a = MUL_W'(r_cz); mul_b = MUL_W'(r_cz); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign sq_trial = r_sq_res + r_sq_bit;
    assign sq_s     = r_sq_res[SQ_W-1:0];
    assign dv_p     = (i_cmd.wop == W_DV_INIT_Y) ? r_ty : r_tx;
    assign dv_mag   = dv_p[T_W-1] ? T_W'(-dv_p) : T_W'(dv_p);
    assign dv_qs    = $signed(ACC_W'(r_dv_q));
    assign coin     = !(r_acc > $signed(ACC_W'(r_eps)));

    always_comb begin
        n_func = r_func; n_px = r_px; n_py = r_py;
        n_adj_w = r_adj_w; n_adj_h = r_adj_h; n_eps = r_eps;
        n_acc = r_acc; n_tx = r_tx; n_ty = r_ty; n_outside = r_outside;
        n_sq_v = r_sq_v; n_sq_res = r_sq_res; n_sq_bit = r_sq_bit;
        n_dv_rem = r_dv_rem; n_dv_den = r_dv_den; n_dv_q = r_dv_q;
        n_ex = r_ex; n_ey = r_ey; n_ez = r_ez;
        n_sx = r_sx; n_sy = r_sy; n_sz = r_sz;
        n_cx = r_cx; n_cy = r_cy; n_cz = r_cz; n_w = r_w;
        n_qx = r_qx; n_qy = r_qy; n_qz = r_qz; n_qw = r_qw; n_coin = r_coin;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADJ_W: n_adj_w = i_cfg_data;
                CFG_ADJ_H: n_adj_h = i_cfg_data;
                CFG_EPS:   n_eps   = i_cfg_data[EPS_W-1:0];
                default:   n_eps   = r_eps;
            endcase
        end

        case (i_cmd.aop)
            A_LOAD:  n_acc = prod;
            A_ADD:   n_acc = r_acc + prod;
            A_SUB:   n_acc = r_acc - prod;
            default: n_acc = r_acc;
        endcase

        case (i_cmd.wop)
            W_IN: begin
                n_func = i_func; n_px = i_pix_x; n_py = i_pix_y;
            end
            W_TX: n_tx = clamp_t(rnd(r_acc - ONE22, SH));
            W_TY: n_ty = clamp_t(rnd(ONE22 - r_acc, SH));
            W_SQ_INIT: begin
                n_outside = (r_acc > $signed(ACC_W'(ONE2)));
                n_sq_v    = n_outside ? r_acc[R_W-1:0] : ONE2 - r_acc[R_W-1:0];
                n_sq_res  = '0;
                n_sq_bit  = BIT0;
            end
            W_SQ_STEP: begin
                if (r_sq_v >= sq_trial) begin
                    n_sq_v   = r_sq_v - sq_trial;
                    n_sq_res = (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    n_sq_res = r_sq_res >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
            end
            W_E_IN: begin
                n_ex = sat_v(ACC_W'(r_tx));
                n_ey = sat_v(ACC_W'(r_ty));
                n_ez = sat_v($signed(ACC_W'(r_sq_res)));
            end
            W_DV_INIT_X, W_DV_INIT_Y: begin
                n_dv_rem = (NW'(dv_mag) << FRAC_BITS) + NW'(sq_s >> 1);
                n_dv_den = DW'(sq_s) << FRAC_BITS;
                n_dv_q   = '0;
            end
            W_DV_STEP: begin
                if (r_dv_rem >= NW'(r_dv_den)) begin
                    n_dv_rem = r_dv_rem - NW'(r_dv_den);
                    n_dv_q   = {r_dv_q[QB-2:0], 1'b1};
                end else begin
                    n_dv_q   = {r_dv_q[QB-2:0], 1'b0};
                end
                n_dv_den = r_dv_den >> 1;
            end
            W_EX_Q: begin
                n_ex = sat_v(r_tx[T_W-1] ? -dv_qs : dv_qs);
                n_ez = '0;
            end
            W_EY_Q: n_ey = sat_v(r_ty[T_W-1] ? -dv_qs : dv_qs);
            W_START: begin
                n_sx = r_ex; n_sy = r_ey; n_sz = r_ez;
            end
            W_CX: n_cx = sat_v(rnd(r_acc, FRAC_BITS));
            W_CY: n_cy = sat_v(rnd(r_acc, FRAC_BITS));
            W_CZ: n_cz = sat_v(rnd(r_acc, FRAC_BITS));
            W_W:  n_w  = sat_v(rnd(r_acc, FRAC_BITS));
            W_OUT: begin
                n_coin = coin;
                n_qx   = coin ? '0 : r_cx;
                n_qy   = coin ? '0 : r_cy;
                n_qz   = coin ? '0 : r_cz;
                n_qw   = coin ? '0 : r_w;
            end
            default: n_func = r_func;
        endcase
    end

    assign o_status.func    = r_func;
    assign o_status.outside = r_outside;
    assign o_quat_x         = r_qx;
    assign o_quat_y         = r_qy;
    assign o_quat_z         = r_qz;
    assign o_quat_w         = r_qw;
    assign o_coincident     = r_coin;

    a_div_by_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wop == W_DV_INIT_X || i_cmd.wop == W_DV_INIT_Y) |-> (sq_s != '0))
        else $error("normalization started with a zero radius");

    a_outside_sqrt_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wop == W_E_IN) |-> !r_outside)
        else $error("inside-circle write-back taken for an outside point");

endmodule
